### hw/rtl/assert_macros.svh
// Shared assertion macros; clk and arst_n must be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HFP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/hfp_pkg.sv
`default_nettype none
package hfp_pkg;

	localparam logic [30:0] MAX_INT_RESET = 31'd65535;
	localparam logic [4:0]  EOS_RUN       = 5'd30;
	localparam logic [2:0]  STEP_LAST     = 3'd5;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_INDEX  = 3'd1,
		PH_NLEN   = 3'd2,
		PH_NLEN_C = 3'd3,
		PH_NAME   = 3'd4,
		PH_VLEN   = 3'd5,
		PH_VLEN_C = 3'd6,
		PH_VALUE  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		IK_NAME   = 2'd0,
		IK_VALUE  = 2'd1,
		IK_RECORD = 2'd2,
		IK_ERROR  = 2'd3
	} item_kind_t;

	typedef enum logic [2:0] {
		REP_INDEXED = 3'd0,
		REP_INCR    = 3'd1,
		REP_NOIDX   = 3'd2,
		REP_NEVER   = 3'd3,
		REP_SIZE    = 3'd4
	} rep_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_LIMIT = 3'd1,
		ERR_ZERO  = 3'd2,
		ERR_LATE  = 3'd3,
		ERR_EOS   = 3'd4,
		ERR_TRUNC = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		INT_INDEX = 2'd0,
		INT_NLEN  = 2'd1,
		INT_VLEN  = 2'd2,
		INT_NONE  = 2'd3
	} int_sel_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  str_byte;
		logic        field_end;
		rep_t        rep;
		logic [30:0] index_or_size;
		logic        name_huff;
		logic        value_huff;
		logic [30:0] name_len;
		logic [30:0] value_len;
		err_t        err;
	} result_t;

	// Walk the octet MSB first; {hit, run after the octet}.
	function automatic logic [5:0] eos_scan(input logic [4:0] run, input logic [7:0] b);
		logic [4:0] r;
		logic       hit;
		r   = run;
		hit = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) begin
				if (r < EOS_RUN)
					r = r + 5'd1;
			end else begin
				r = '0;
			end
			if (r >= EOS_RUN)
				hit = 1'b1;
		end
		return {hit, r};
	endfunction

endpackage
`default_nettype wire

### hw/rtl/hfp_core.sv
`default_nettype none
module hfp_core
	import hfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	input  wire logic [30:0] max_integer,
	output logic             emit,
	output result_t          res
);

`include "assert_macros.svh"

	phase_t      phase_q, phase_n;
	rep_t        kind_q, kind_n;
	logic [31:0] acc_q, acc_n;
	logic [2:0]  step_q, step_n;
	logic        ovf_q, ovf_n;
	logic [30:0] index_q, index_n;
	logic [30:0] nlen_q, nlen_n;
	logic [30:0] vlen_q, vlen_n;
	logic [30:0] left_q, left_n;
	logic [1:0]  huff_q, huff_n;
	logic [4:0]  run_q, run_n;
	logic        upd_q, upd_n;
	logic        disc_q, disc_n;

	// continuation octet arithmetic
	logic [6:0]  cont_v;
	logic [35:0] cont_sh;
	logic [35:0] cont_sum;
	logic [31:0] cont_acc;
	logic        cont_ovf;
	logic [2:0]  cont_step;
	logic [5:0]  eos_res;

	always_comb begin
		cont_v = data_byte[6:0];
		case (step_q)
			3'd0: cont_sh = 36'(cont_v);
			3'd1: cont_sh = 36'(cont_v) << 7;
			3'd2: cont_sh = 36'(cont_v) << 14;
			3'd3: cont_sh = 36'(cont_v) << 21;
			3'd4: cont_sh = 36'(cont_v) << 28;
			default: cont_sh = '0;
		endcase
		cont_sum = 36'(acc_q) + cont_sh;
		cont_acc = acc_q;
		cont_ovf = ovf_q;
		if (cont_v != 7'd0) begin
			if (step_q >= STEP_LAST)
				cont_ovf = 1'b1;
			else if (cont_sum[35:32] != 4'd0)
				cont_ovf = 1'b1;
			else
				cont_acc = cont_sum[31:0];
		end
		cont_step = (step_q < STEP_LAST) ? step_q + 3'd1 : step_q;
		eos_res = eos_scan(run_q, data_byte);
	end

	logic       complete;
	int_sel_t   which;
	err_t       err;
	item_kind_t ik;
	logic [7:0] sb;
	logic       fend;
	logic [7:0] mask;

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		acc_n    = acc_q;
		step_n   = step_q;
		ovf_n    = ovf_q;
		index_n  = index_q;
		nlen_n   = nlen_q;
		vlen_n   = vlen_q;
		left_n   = left_q;
		huff_n   = huff_q;
		run_n    = run_q;
		upd_n    = upd_q;
		disc_n   = disc_q;
		complete = 1'b0;
		which    = INT_NONE;
		err      = ERR_NONE;
		emit     = 1'b0;
		ik       = IK_RECORD;
		sb       = '0;
		fend     = 1'b0;
		mask     = 8'h7f;

		if (disc_q) begin
			// drop octets up to the block end
			if (last) begin
				disc_n  = 1'b0;
				phase_n = PH_START;
				upd_n   = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_START: begin
					if (data_byte[7]) begin
						kind_n = REP_INDEXED; mask = 8'h7f;
					end else if (data_byte[6]) begin
						kind_n = REP_INCR; mask = 8'h3f;
					end else if (data_byte[5]) begin
						kind_n = REP_SIZE; mask = 8'h1f;
					end else if (data_byte[4]) begin
						kind_n = REP_NEVER; mask = 8'h0f;
					end else begin
						kind_n = REP_NOIDX; mask = 8'h0f;
					end
					index_n = '0;
					nlen_n  = '0;
					vlen_n  = '0;
					huff_n  = '0;
					left_n  = '0;
					run_n   = '0;
					if (kind_n != REP_SIZE)
						upd_n = 1'b0;
					acc_n  = {24'd0, data_byte & mask};
					step_n = '0;
					ovf_n  = 1'b0;
					if ((data_byte & mask) != mask) begin
						complete = 1'b1;
						which    = INT_INDEX;
					end else begin
						phase_n = PH_INDEX;
					end
				end
				PH_INDEX, PH_NLEN_C, PH_VLEN_C: begin
					acc_n  = cont_acc;
					ovf_n  = cont_ovf;
					step_n = cont_step;
					if (!data_byte[7]) begin
						complete = 1'b1;
						case (phase_q)
							PH_INDEX:  which = INT_INDEX;
							PH_NLEN_C: which = INT_NLEN;
							default:   which = INT_VLEN;
						endcase
					end
				end
				PH_NLEN, PH_VLEN: begin
					if (phase_q == PH_NLEN)
						huff_n[0] = huff_q[0] | data_byte[7];
					else
						huff_n[1] = huff_q[1] | data_byte[7];
					acc_n  = {25'd0, data_byte[6:0]};
					step_n = '0;
					ovf_n  = 1'b0;
					if (data_byte[6:0] != 7'h7f) begin
						complete = 1'b1;
						which    = (phase_q == PH_NLEN) ? INT_NLEN : INT_VLEN;
					end else begin
						phase_n = (phase_q == PH_NLEN) ? PH_NLEN_C : PH_VLEN_C;
					end
				end
				PH_NAME, PH_VALUE: begin
					run_n = eos_res[4:0];
					if (eos_res[5]) begin
						err = ERR_EOS;
					end else begin
						emit   = 1'b1;
						sb     = data_byte;
						left_n = left_q - 31'd1;
						if (phase_q == PH_NAME) begin
							ik = IK_NAME;
							if (left_n == '0)
								phase_n = PH_VLEN;
						end else begin
							ik = IK_VALUE;
							if (left_n == '0) begin
								phase_n = PH_START;
								fend    = 1'b1;
							end
						end
					end
				end
				default: phase_n = PH_START;
			endcase

			if (complete) begin
				if (ovf_n || (acc_n > {1'b0, max_integer})) begin
					err = ERR_LIMIT;
				end else begin
					case (which)
						INT_INDEX: begin
							index_n = acc_n[30:0];
							if (kind_n == REP_INDEXED) begin
								if (index_n == '0) begin
									err = ERR_ZERO;
								end else begin
									phase_n = PH_START;
									emit    = 1'b1;
									fend    = 1'b1;
								end
							end else if (kind_n == REP_SIZE) begin
								if (!upd_n) begin
									err = ERR_LATE;
								end else begin
									phase_n = PH_START;
									emit    = 1'b1;
									fend    = 1'b1;
								end
							end else begin
								phase_n = (index_n == '0) ? PH_NLEN : PH_VLEN;
							end
						end
						INT_NLEN: begin
							nlen_n  = acc_n[30:0];
							left_n  = acc_n[30:0];
							run_n   = '0;
							phase_n = (acc_n == '0) ? PH_VLEN : PH_NAME;
						end
						INT_VLEN: begin
							vlen_n = acc_n[30:0];
							left_n = acc_n[30:0];
							run_n  = '0;
							if (acc_n == '0) begin
								phase_n = PH_START;
								emit    = 1'b1;
								fend    = 1'b1;
							end else begin
								phase_n = PH_VALUE;
							end
						end
						default: ;
					endcase
				end
			end

			if (err == ERR_NONE && last && phase_n != PH_START)
				err = ERR_TRUNC;

			if (err != ERR_NONE) begin
				emit    = 1'b1;
				ik      = IK_ERROR;
				sb      = '0;
				fend    = 1'b0;
				phase_n = PH_START;
				if (last)
					upd_n = 1'b1;
				else
					disc_n = 1'b1;
			end else if (last) begin
				phase_n = PH_START;
				upd_n   = 1'b1;
			end
		end
	end

	always_comb begin
		res.kind          = ik;
		res.str_byte      = sb;
		res.field_end     = fend;
		res.rep           = kind_n;
		res.index_or_size = index_n;
		res.name_huff     = huff_n[0];
		res.value_huff    = huff_n[1];
		res.name_len      = nlen_n;
		res.value_len     = vlen_n;
		res.err           = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			kind_q  <= REP_INDEXED;
			acc_q   <= '0;
			step_q  <= '0;
			ovf_q   <= 1'b0;
			index_q <= '0;
			nlen_q  <= '0;
			vlen_q  <= '0;
			left_q  <= '0;
			huff_q  <= '0;
			run_q   <= '0;
			upd_q   <= 1'b1;
			disc_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			acc_q   <= acc_n;
			step_q  <= step_n;
			ovf_q   <= ovf_n;
			index_q <= index_n;
			nlen_q  <= nlen_n;
			vlen_q  <= vlen_n;
			left_q  <= left_n;
			huff_q  <= huff_n;
			run_q   <= run_n;
			upd_q   <= upd_n;
			disc_q  <= disc_n;
		end
	end

	`HFP_ASSERT(a_discard_silent, disc_q, !emit, "result produced while discarding")
	`HFP_ASSERT(a_string_left, !disc_q && (phase_q == PH_NAME || phase_q == PH_VALUE),
		left_q != '0, "string phase with no octets left")
	`HFP_ASSERT_NEXT(a_error_discard, fire && emit && res.kind == IK_ERROR && !last,
		disc_q, "error inside block did not start discarding")

endmodule
`default_nettype wire

### hw/rtl/hpack_header_field_parser_top.sv
// HPACK header representation parser, one octet per beat.
// out_valid rises once the octet has passed the input register, the parse logic and the
// result register; the result beat can be held up by out_ready on the way.
// Throughput: one octet per cycle while out_ready stays high; a held result stalls the
// input once the input register is also full.
// Reset (arst_n, asynchronous): parser at start of representation, size updates
// allowed, max_integer back to 65535, both pipeline stages empty.
`default_nettype none
module hpack_header_field_parser_top
	import hfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [30:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_in_block,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       item_kind,
	output logic [7:0]       string_byte,
	output logic             field_end,
	output logic [2:0]       representation,
	output logic [30:0]      index_or_size,
	output logic             name_huffman,
	output logic             value_huffman,
	output logic [30:0]      name_octets,
	output logic [30:0]      value_octets,
	output logic [2:0]       error_code
);

`include "assert_macros.svh"

	logic [30:0] max_int_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        advance;
	logic        emit;
	result_t     res;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_int_q <= MAX_INT_RESET;
		else if (cfg_we)
			max_int_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_in_block;
		end
	end

	hfp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.data_byte   (byte_s1),
		.last        (last_s1),
		.max_integer (max_int_q),
		.emit        (emit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign item_kind      = res_s2.kind;
	assign string_byte    = res_s2.str_byte;
	assign field_end      = res_s2.field_end;
	assign representation = res_s2.rep;
	assign index_or_size  = res_s2.index_or_size;
	assign name_huffman   = res_s2.name_huff;
	assign value_huffman  = res_s2.value_huff;
	assign name_octets    = res_s2.name_len;
	assign value_octets   = res_s2.value_len;
	assign error_code     = res_s2.err;

	`HFP_ASSERT(a_hold_input, valid_s1 && valid_s2 && !out_ready, !in_ready,
		"input taken while both stages are stalled")
	`HFP_ASSERT(a_ready_empty, !valid_s1, in_ready, "input register empty but not ready")
	`HFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_s2),
		"result beat dropped or changed while stalled")

endmodule
`default_nettype wire
